/* hdl/cle_pkg.sv */
// cle_pkg: shared types and constants of the console line editor.
// Holds the command record passed from the front end to the back end through the queue.
// No dependencies.
package cle_pkg;

	// result kinds
	localparam logic [1:0] KIND_TERM = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_OVER = 2'd2;
	localparam logic [1:0] KIND_READ = 2'd3;

	// request types
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// character codes
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_PROMPT = 8'h3E;

	localparam logic [7:0] BUF_SIZE_RESET = 8'd128;

	// command queue
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// one classified item, expanded into results by the back end
	typedef struct packed {
		logic       is_read;
		logic       prompt_first;
		logic       crlf;
		logic       done;
		logic       bs;
		logic       over;
		logic [7:0] data;
		logic [7:0] len;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qent_t;

endpackage

/* hdl/console_line_editor_top.sv */
// console_line_editor_top: top level of the console line editor.
// Connects cle_front, cle_queue and cle_back. Depends on cle_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall): req_type 0 carries a received terminal
//   byte in rx_byte; req_type 1 reads line store position read_index.
//   Output channel (out_valid/out_stall): one result per transfer with kind,
//   data_byte, line_length and last; last marks the final result of an item.
//   Config channel (cfg_valid/cfg_ready): writes buffer_size; always ready.
//   Results pass the front stage register, the queue and the output register.
//   Throughput: one result per cycle while out_stall is low. An item yields
//   1 to 8 results, walked by the output register, which sets this figure.
//   Up to 4 classified items wait in the command queue plus one in the front
//   stage; input transfers continue until that space is used.
//   A stalled receiver holds the current result; items keep entering until
//   the queue fills, then in_stall rises.
//   Reset: line empty, buffer_size 128, prompt ">>" pending before the next
//   received byte's echo. The line store is not cleared; no clearing pass.
module console_line_editor_top import cle_pkg::*; #(
	parameter int BUF_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  rx_byte,
	input  logic [6:0]  read_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  line_length,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	qent_t push;
	qent_t head;
	logic  q_full;
	logic  pop;

	cle_front #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.rx_byte   (rx_byte),
		.read_index(read_index),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.q_full    (q_full)
	);

	cle_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (q_full),
		.head  (head),
		.pop   (pop)
	);

	cle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.line_length(line_length),
		.last       (last)
	);

endmodule

/* hdl/cle_front.sv */
// cle_front: accepts items, classifies them, updates the line state and the line store.
// Holds the buffer_size register; pushes one cmd_t per item into the command queue.
// Depends on cle_pkg.
module cle_front import cle_pkg::*; #(
	parameter int BUF_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  rx_byte,
	input  logic [6:0]  read_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output qent_t       push,
	input  logic        q_full
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CAP = (BUF_DEPTH < 255) ? BUF_DEPTH : 255;
	localparam logic [7:0] CAP8 = 8'(CAP);

	logic [7:0] line_mem [BUF_DEPTH];

	logic [7:0] buffer_size_q;
	logic [7:0] fill_count_q;
	logic [7:0] shown_len_q;
	logic       prompt_pending_q;

	logic       valid_s1;
	cmd_t       cmd_s1;
	logic       rd_ok_s1;
	logic [7:0] rd_data_s1;

	logic       adv;
	logic       accept;
	logic       do_push;
	logic       is_end;
	logic       is_bs;
	logic       is_print;
	logic [7:0] limit;
	logic       store_wr;
	cmd_t       cmd_new;
	logic [7:0] fill_nxt;
	logic [7:0] shown_nxt;

	assign cfg_ready = 1'b1;
	assign do_push   = valid_s1 && !q_full;
	assign adv       = !valid_s1 || !q_full;
	assign in_stall  = !adv;
	assign accept    = in_valid && adv;

	assign is_end   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
	assign is_bs    = (rx_byte == CH_BS);
	assign is_print = (rx_byte >= CH_SP) && (rx_byte <= CH_TILDE);
	assign limit    = (buffer_size_q < CAP8) ? buffer_size_q : CAP8;

	always_comb begin
		cmd_new   = '0;
		fill_nxt  = fill_count_q;
		shown_nxt = shown_len_q;
		store_wr  = 1'b0;
		cmd_new.data = rx_byte;
		if (req_type == REQ_READ) begin
			cmd_new.is_read = 1'b1;
		end else begin
			cmd_new.prompt_first = prompt_pending_q;
			priority if (is_end) begin
				cmd_new.crlf = 1'b1;
				cmd_new.done = (fill_count_q != 8'd0);
				cmd_new.len  = fill_count_q;
				if (fill_count_q != 8'd0) begin
					shown_nxt = fill_count_q;
				end
				fill_nxt = 8'd0;
			end else if (is_bs) begin
				if (fill_count_q != 8'd0) begin
					cmd_new.bs = 1'b1;
					fill_nxt   = fill_count_q - 8'd1;
				end
			end else if (is_print) begin
				if (fill_count_q < limit) begin
					store_wr  = 1'b1;
					fill_nxt  = fill_count_q + 8'd1;
					shown_nxt = 8'd0;
				end else begin
					cmd_new.over = 1'b1;
					fill_nxt     = 8'd0;
				end
			end else begin
				// other bytes (control and high bytes): echo only
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q    <= BUF_SIZE_RESET;
			fill_count_q     <= 8'd0;
			shown_len_q      <= 8'd0;
			prompt_pending_q <= 1'b1;
			valid_s1         <= 1'b0;
		end else begin
			if (cfg_valid) begin
				buffer_size_q <= cfg_data;
			end
			if (accept) begin
				fill_count_q <= fill_nxt;
				shown_len_q  <= shown_nxt;
				if (req_type == REQ_BYTE) begin
					prompt_pending_q <= 1'b0;
				end
				valid_s1 <= 1'b1;
			end else if (do_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// payload of stage 1 and the line store
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd_new;
			rd_ok_s1   <= ({1'b0, read_index} < shown_len_q);
			rd_data_s1 <= line_mem[AW'(read_index)];
			if (store_wr) begin
				line_mem[AW'(fill_count_q)] <= rx_byte;
			end
		end
	end

	always_comb begin
		push.valid = do_push;
		push.cmd   = cmd_s1;
		if (cmd_s1.is_read) begin
			push.cmd.data = rd_ok_s1 ? rd_data_s1 : 8'd0;
		end
	end

endmodule

/* hdl/cle_queue.sv */
// cle_queue: short command queue between front end and back end.
// Registered entries with read and write pointers and an occupancy count.
// Depends on cle_pkg.
module cle_queue import cle_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  qent_t push,
	output logic  full,
	output qent_t head,
	input  logic  pop
);

	cmd_t           entry_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == (QAW+1)'(QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

endmodule

/* hdl/cle_back.sv */
// cle_back: expands each command into ordered results, one per unstalled cycle.
// Walks a mask of result slots and drives the registered output channel.
// Depends on cle_pkg.
module cle_back import cle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  qent_t       head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  line_length,
	output logic        last
);

	// result slots in emission order
	localparam int NSLOT = 11;
	localparam logic [3:0] SL_P0   = 4'd0;
	localparam logic [3:0] SL_P1   = 4'd1;
	localparam logic [3:0] SL_ECHO = 4'd2;
	localparam logic [3:0] SL_CR   = 4'd3;
	localparam logic [3:0] SL_LF   = 4'd4;
	localparam logic [3:0] SL_DONE = 4'd5;
	localparam logic [3:0] SL_Q0   = 4'd6;
	localparam logic [3:0] SL_Q1   = 4'd7;
	localparam logic [3:0] SL_SP   = 4'd8;
	localparam logic [3:0] SL_BS   = 4'd9;
	localparam logic [3:0] SL_OVER = 4'd10;

	function automatic logic [NSLOT-1:0] slot_mask(input cmd_t c);
		logic [NSLOT-1:0] m;
		m = '0;
		m[SL_P0]   = c.prompt_first;
		m[SL_P1]   = c.prompt_first;
		m[SL_ECHO] = 1'b1;
		m[SL_CR]   = c.crlf;
		m[SL_LF]   = c.crlf;
		m[SL_DONE] = c.done;
		m[SL_Q0]   = c.crlf;
		m[SL_Q1]   = c.crlf;
		m[SL_SP]   = c.bs;
		m[SL_BS]   = c.bs;
		m[SL_OVER] = c.over;
		return m;
	endfunction

	cmd_t             cmd_q;
	logic [NSLOT-1:0] mask_q;
	logic             out_valid_q;
	logic [1:0]       kind_q;
	logic [7:0]       data_q;
	logic [7:0]       len_q;
	logic             last_q;

	logic             busy;
	logic             adv;
	logic             go;
	cmd_t             sel_cmd;
	logic [NSLOT-1:0] sel_mask;
	logic [NSLOT-1:0] low;
	logic [NSLOT-1:0] rest;
	logic [3:0]       slot;
	logic [1:0]       kind_n;
	logic [7:0]       data_n;
	logic [7:0]       len_n;

	assign busy     = (mask_q != '0);
	assign adv      = !out_valid_q || !out_stall;
	assign go       = adv && (busy || head.valid);
	assign pop      = adv && !busy && head.valid;
	assign sel_cmd  = busy ? cmd_q : head.cmd;
	assign sel_mask = busy ? mask_q : slot_mask(head.cmd);
	assign low      = sel_mask & (~sel_mask + 1'b1);
	assign rest     = sel_mask & ~low;

	always_comb begin
		slot = SL_P0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (low[i]) begin
				slot = 4'(i);
			end
		end
	end

	always_comb begin
		kind_n = KIND_TERM;
		data_n = 8'd0;
		len_n  = 8'd0;
		unique case (slot)
			SL_P0, SL_P1, SL_Q0, SL_Q1: data_n = CH_PROMPT;
			SL_ECHO: begin
				kind_n = sel_cmd.is_read ? KIND_READ : KIND_TERM;
				data_n = sel_cmd.data;
			end
			SL_CR: data_n = CH_CR;
			SL_LF: data_n = CH_LF;
			SL_DONE: begin
				kind_n = KIND_DONE;
				len_n  = sel_cmd.len;
			end
			SL_SP: data_n = CH_SP;
			SL_BS: data_n = CH_BS;
			SL_OVER: kind_n = KIND_OVER;
			default: kind_n = KIND_TERM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mask_q      <= '0;
		end else if (adv) begin
			out_valid_q <= go;
			if (go) begin
				mask_q <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			kind_q <= kind_n;
			data_q <= data_n;
			len_q  <= len_n;
			last_q <= (rest == '0);
			if (pop) begin
				cmd_q <= head.cmd;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign data_byte   = data_q;
	assign line_length = len_q;
	assign last        = last_q;

endmodule

/* bench/console_line_editor_top_tb.sv */
// console_line_editor_top_tb: self-checking bench for the console line editor top level.
// Drives terminal bytes and line reads, predicts echo/prompt/line/overflow results in a scoreboard.
// Depends on cle_pkg and console_line_editor_top.
module console_line_editor_top_tb import cle_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 128;
	localparam int QUIET_LIMIT = 5000;
	localparam int SHOW_LIMIT  = 30;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] data;
		logic [7:0] len;
		logic       last;
	} result_t;

	class line_scoreboard;
		result_t    pending_results[$];
		logic [7:0] line_chars [STORE_DEPTH];
		int         line_fill;
		int         reported_len;
		bit         prompt_due;
		int         line_limit;
		int         errors;
		int         checked;
		int         reads;
		int         lines_done;
		int         overflows;

		function new();
			line_fill    = 0;
			reported_len = 0;
			prompt_due   = 1'b1;
			line_limit   = BUF_SIZE_RESET;
			errors       = 0;
			checked      = 0;
			reads        = 0;
			lines_done   = 0;
			overflows    = 0;
		endfunction

		function void set_line_limit(logic [7:0] v);
			line_limit = v;
		endfunction

		function result_t make_result(logic [1:0] k, logic [7:0] d, logic [7:0] n);
			result_t r;
			r.kind = k;
			r.data = d;
			r.len  = n;
			r.last = 1'b0;
			return r;
		endfunction

		// expand one accepted item into the results it should produce
		function void note_item(logic rq, logic [7:0] ch, logic [6:0] idx);
			result_t outs[$];
			int lim;
			if (rq == REQ_READ) begin
				reads++;
				outs.push_back(make_result(KIND_READ,
					(idx < reported_len) ? line_chars[idx] : 8'd0, 8'd0));
			end else begin
				if (prompt_due) begin
					outs.push_back(make_result(KIND_TERM, CH_PROMPT, 8'd0));
					outs.push_back(make_result(KIND_TERM, CH_PROMPT, 8'd0));
					prompt_due = 1'b0;
				end
				outs.push_back(make_result(KIND_TERM, ch, 8'd0));
				if (ch == CH_CR || ch == CH_LF) begin
					outs.push_back(make_result(KIND_TERM, CH_CR, 8'd0));
					outs.push_back(make_result(KIND_TERM, CH_LF, 8'd0));
					if (line_fill > 0) begin
						outs.push_back(make_result(KIND_DONE, 8'd0, line_fill[7:0]));
						reported_len = line_fill;
						line_fill = 0;
					end
					outs.push_back(make_result(KIND_TERM, CH_PROMPT, 8'd0));
					outs.push_back(make_result(KIND_TERM, CH_PROMPT, 8'd0));
				end else if (ch == CH_BS) begin
					if (line_fill > 0) begin
						line_fill--;
						outs.push_back(make_result(KIND_TERM, CH_SP, 8'd0));
						outs.push_back(make_result(KIND_TERM, CH_BS, 8'd0));
					end
				end else if (ch >= CH_SP && ch <= CH_TILDE) begin
					lim = (line_limit < STORE_DEPTH) ? line_limit : STORE_DEPTH;
					if (line_fill < lim) begin
						line_chars[line_fill] = ch;
						line_fill++;
						reported_len = 0;
					end else begin
						outs.push_back(make_result(KIND_OVER, 8'd0, 8'd0));
						line_fill = 0;
					end
				end
			end
			outs[outs.size() - 1].last = 1'b1;
			foreach (outs[i])
				pending_results.push_back(outs[i]);
		endfunction

		task report_mismatch(string what, int got, int want);
			if (errors < SHOW_LIMIT)
				$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
					$time, what, got, want);
			errors++;
		endtask

		task check_result(logic [1:0] k, logic [7:0] d, logic [7:0] n, logic lst);
			result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result kind", k, 0);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (k == KIND_DONE)
				lines_done++;
			if (k == KIND_OVER)
				overflows++;
			if (k !== want.kind)
				report_mismatch("kind", k, want.kind);
			if (d !== want.data)
				report_mismatch("data_byte", d, want.data);
			if (n !== want.len)
				report_mismatch("line_length", n, want.len);
			if (lst !== want.last)
				report_mismatch("last", lst, want.last);
		endtask
	endclass

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic       req_type    = 1'b0;
	logic [7:0] rx_byte     = 8'd0;
	logic [6:0] read_index  = 7'd0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] line_length;
	logic       last;
	logic       cfg_valid   = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data    = 8'd0;

	line_scoreboard sb = new();

	int sender_idle_pct = 0;
	int recv_idle_pct   = 0;
	int hold_left       = 0;
	int items_sent      = 0;
	int cfg_writes      = 0;
	int quiet           = 0;

	console_line_editor_top #(
		.BUF_DEPTH(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.rx_byte(rx_byte),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.data_byte(data_byte),
		.line_length(line_length),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: random stall, or a long hold-off when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(kind, data_byte, line_length, last);
	end

	// watchdog: too long without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Timeout: %0d cycles without a transfer, %0d results outstanding",
				quiet, sb.pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet = quiet + 1;
		end
	end

	task send_item(logic rq, logic [7:0] b, logic [6:0] idx);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= rq;
		rx_byte    <= b;
		read_index <= idx;
		do @(posedge clk); while (in_stall);
		sb.note_item(rq, b, idx);
		items_sent++;
	endtask

	task send_byte(logic [7:0] b);
		send_item(REQ_BYTE, b, 7'($urandom_range(127)));
	endtask

	task send_read(logic [6:0] idx);
		send_item(REQ_READ, 8'($urandom_range(255)), idx);
	endtask

	// buffer size only changes with nothing in flight
	task write_size(logic [7:0] v);
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_line_limit(v);
		cfg_writes++;
	endtask

	// one typed line: printable text with some editing and noise, usually terminated,
	// then a few reads of the reported line
	task automatic send_line(int len, bit clean);
		int r;
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (!clean && r < 8)
				b = CH_BS;
			else if (!clean && r < 13)
				b = 8'($urandom_range(255));
			else
				b = 8'($urandom_range(CH_TILDE, CH_SP));
			send_byte(b);
		end
		if (clean || $urandom_range(9) != 0)
			send_byte($urandom_range(1) ? CH_CR : CH_LF);
		repeat ($urandom_range(3))
			send_read(7'(($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(len)));
	endtask

	initial begin
		int sizes [6];
		int start;
		int lsize;
		sizes = '{128, 1, 0, 128, 3, 1};
		sizes[2] = $urandom_range(127, 2);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		sender_idle_pct = 20;
		recv_idle_pct   = 84;
		@(posedge clk);

		// directed: read with prompt still due, empty line end, edit keys, control
		// and high bytes, a completed line and reads in and out of range
		send_read(7'd0);
		send_byte(CH_CR);
		send_byte(8'h41);
		send_byte(CH_SP);
		send_byte(CH_TILDE);
		send_byte(CH_BS);
		send_byte(8'h7F);
		send_byte(8'h1F);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h7A);
		send_byte(CH_LF);
		send_read(7'd0);
		send_read(7'd2);
		send_read(7'd3);
		send_read(7'd127);
		send_byte(CH_BS);
		send_byte(CH_CR);
		// one-byte buffer: second printable overflows
		write_size(8'd1);
		send_byte(8'h61);
		send_byte(8'h62);
		send_byte(8'h63);
		send_byte(CH_LF);
		send_read(7'd0);

		for (int ph = 0; ph < 6; ph++) begin
			sender_idle_pct = (ph / 2 == 0) ? 20 : (ph / 2 == 1) ? 84 : 0;
			recv_idle_pct   = (ph / 2 == 0) ? 84 : (ph / 2 == 1) ? 20 : 0;
			lsize = sizes[ph];
			write_size(lsize[7:0]);
			start = items_sent;
			if (ph == 3)
				send_line(STORE_DEPTH + 2, 1'b1);
			if (ph == 4)
				hold_left = 400;
			while (items_sent - start < 50)
				send_line((lsize <= 16) ? $urandom_range(lsize + 2) : $urandom_range(14), 1'b0);
		end

		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d items (%0d line reads) over %0d buffer size writes, sizes 1 to 128",
			items_sent, sb.reads, cfg_writes);
		$display("Checked %0d results: %0d completed lines, %0d overflows, %0d mismatches",
			sb.checked, sb.lines_done, sb.overflows, sb.errors);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hdl/cle_pkg.sv
hdl/cle_front.sv
hdl/cle_queue.sv
hdl/cle_back.sv
hdl/console_line_editor_top.sv
bench/console_line_editor_top_tb.sv
